@@ rtl/krls_pkg.sv @@
package krls_pkg;

    // buffer geometry
    localparam int BUFFER_DEPTH = 16;
    localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int ENTRY_W      = 9;

    // command queue between front and back
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    // stream widths
    localparam int S_DATA_W     = 16;
    localparam int M_DATA_W     = 16;

    // key codes
    localparam logic [7:0] BKSP_CODE     = 8'd14;
    localparam logic [7:0] KEY_S         = 8'd31;
    localparam logic [7:0] SPACE_CODE    = 8'd57;
    localparam logic [7:0] PAUSE_CODE    = 8'd119;
    localparam logic [7:0] TOGGLE_RESET  = 8'd58;

    // key event values
    localparam logic [1:0] KEY_VAL_RELEASE = 2'd0;
    localparam logic [1:0] KEY_VAL_PRESS   = 2'd1;

    // modifier mask groups
    localparam logic [7:0] MASK_SHIFT = 8'h03;
    localparam logic [7:0] MASK_ALT   = 8'hC0;

    // result kinds
    localparam logic ACTION_TAP     = 1'b0;
    localparam logic ACTION_CONVERT = 1'b1;

    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_LAYOUT = 2'd1,
        PEND_CASE   = 2'd2
    } pend_t;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_RETYPE  = 2'd1,
        CMD_CONVERT = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [IDX_W-1:0]     addr;
        logic [ENTRY_W-1:0]   entry;
        logic [CNT_W-1:0]     count;
        logic                 mode;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_ERASE  = 2'd1,
        BK_TOGGLE = 2'd2,
        BK_REPLAY = 2'd3
    } back_state_t;

    // modifier key to mask bit
    function automatic logic [7:0] modifier_bit(input logic [7:0] code);
        logic [7:0] bit_val;
        unique case (code)
            8'd42:   bit_val = 8'h01;
            8'd54:   bit_val = 8'h02;
            8'd29:   bit_val = 8'h04;
            8'd97:   bit_val = 8'h08;
            8'd125:  bit_val = 8'h10;
            8'd126:  bit_val = 8'h20;
            8'd56:   bit_val = 8'h40;
            8'd100:  bit_val = 8'h80;
            default: bit_val = 8'h00;
        endcase
        return bit_val;
    endfunction

    // keys that go into the retype buffer
    function automatic logic is_printable(input logic [7:0] c);
        return (c >= 8'd2  && c <= 8'd12) || (c >= 8'd16 && c <= 8'd27) ||
               (c >= 8'd30 && c <= 8'd41) || (c >= 8'd44 && c <= 8'd52) ||
               (c >= 8'd71 && c <= 8'd73) || (c >= 8'd75 && c <= 8'd77) ||
               (c >= 8'd79 && c <= 8'd82);
    endfunction

endpackage

@@ rtl/krls_queue.sv @@
module krls_queue
    import krls_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      pop_cmd,
    output q_status_t q_stat
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;

    // status and head entry
    assign q_stat.full  = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_stat.empty = (fill_reg == '0);
    assign pop_cmd      = slot_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - (QPTR_W+1)'(1);
            end
        end
    end

    // command storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/krls_front.sv @@
module krls_front
    import krls_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  q_status_t           q_stat,
    output logic                q_push,
    output cmd_t                q_cmd
);

    logic [7:0]       mask_reg, mask_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             word_ended_reg, word_ended_next;
    pend_t            pend_reg, pend_next;

    logic [7:0]       code;
    logic [1:0]       key_val;
    logic [7:0]       mbit;
    logic             accept;
    logic             buf_full;
    logic [CNT_W-1:0] print_base;
    logic [CNT_W-1:0] space_base;
    logic             is_press;

    assign s_tready   = !q_stat.full;
    assign accept     = s_tvalid && s_tready;
    assign code       = s_tdata[7:0];
    assign key_val    = s_tdata[9:8];
    assign mbit       = modifier_bit(code);
    assign is_press   = (key_val == KEY_VAL_PRESS);
    assign buf_full   = (count_reg >= CNT_W'(BUFFER_DEPTH));
    assign print_base = (buf_full || word_ended_reg) ? '0 : count_reg;
    assign space_base = buf_full ? '0 : count_reg;

    // classify the event and build the command for the back end
    always_comb begin
        mask_next       = mask_reg;
        count_next      = count_reg;
        word_ended_next = word_ended_reg;
        pend_next       = pend_reg;
        q_push          = 1'b0;
        q_cmd.kind      = CMD_WRITE;
        q_cmd.addr      = '0;
        q_cmd.entry     = '0;
        q_cmd.count     = count_reg;
        q_cmd.mode      = (pend_reg == PEND_CASE);
        if (accept && s_tuser) begin
            if (mbit != 8'h00) begin
                mask_next = (key_val != KEY_VAL_RELEASE) ? (mask_reg | mbit)
                                                         : (mask_reg & ~mbit);
                if (mask_next == 8'h00 && pend_reg != PEND_NONE) begin
                    q_push     = 1'b1;
                    q_cmd.kind = CMD_CONVERT;
                    pend_next  = PEND_NONE;
                end
            end else if (is_printable(code)) begin
                if (is_press) begin
                    if ((mask_reg & ~MASK_SHIFT) != 8'h00) begin
                        if (code != KEY_S) begin
                            count_next = '0;
                        end
                    end else begin
                        q_push          = 1'b1;
                        q_cmd.kind      = CMD_WRITE;
                        q_cmd.addr      = print_base[IDX_W-1:0];
                        q_cmd.entry     = {((mask_reg & MASK_SHIFT) != 8'h00), code};
                        count_next      = print_base + CNT_W'(1);
                        word_ended_next = 1'b0;
                    end
                end
            end else if (code == SPACE_CODE && mask_reg == 8'h00) begin
                if (is_press) begin
                    q_push          = 1'b1;
                    q_cmd.kind      = CMD_WRITE;
                    q_cmd.addr      = space_base[IDX_W-1:0];
                    q_cmd.entry     = {1'b0, code};
                    count_next      = space_base + CNT_W'(1);
                    word_ended_next = 1'b1;
                end
            end else if (code == BKSP_CODE && mask_reg == 8'h00) begin
                if (is_press && count_reg != '0) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end else if (code == PAUSE_CODE && mask_reg == 8'h00) begin
                if (is_press && count_reg != '0) begin
                    q_push     = 1'b1;
                    q_cmd.kind = CMD_RETYPE;
                end
            end else if (code == PAUSE_CODE && (mask_reg & MASK_ALT) != 8'h00) begin
                if (is_press) begin
                    count_next      = '0;
                    word_ended_next = 1'b0;
                    pend_next       = PEND_LAYOUT;
                end
            end else if (code == PAUSE_CODE && (mask_reg & MASK_SHIFT) != 8'h00) begin
                if (is_press) begin
                    count_next      = '0;
                    word_ended_next = 1'b0;
                    pend_next       = PEND_CASE;
                end
            end else begin
                count_next      = '0;
                word_ended_next = 1'b0;
            end
        end
    end

    // tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg       <= '0;
            count_reg      <= '0;
            word_ended_reg <= 1'b0;
            pend_reg       <= PEND_NONE;
        end else begin
            mask_reg       <= mask_next;
            count_reg      <= count_next;
            word_ended_reg <= word_ended_next;
            pend_reg       <= pend_next;
        end
    end

endmodule

@@ rtl/krls_back.sv @@
module krls_back
    import krls_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  q_status_t           q_stat,
    input  cmd_t                q_cmd,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    back_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [7:0]         toggle_reg;
    logic [ENTRY_W-1:0] mem [BUFFER_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic               m_tvalid_reg;
    logic               out_action_reg;
    logic [7:0]         out_code_reg;
    logic               out_shift_reg;
    logic               out_mode_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               idx_last;
    logic               mem_we;
    logic               emit;
    logic               emit_action;
    logic [7:0]         emit_code;
    logic               emit_shift;
    logic               emit_mode;
    logic               emit_last;

    assign out_free = !m_tvalid_reg || m_tready;
    assign idx_last = (CNT_W'(idx_reg) == cnt_reg - CNT_W'(1));

    // sequencer: buffer writes, conversion requests, retype runs
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        emit        = 1'b0;
        emit_action = ACTION_TAP;
        emit_code   = BKSP_CODE;
        emit_shift  = 1'b0;
        emit_mode   = 1'b0;
        emit_last   = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    unique case (q_cmd.kind)
                        CMD_WRITE: begin
                            mem_we = 1'b1;
                            q_pop  = 1'b1;
                        end
                        CMD_RETYPE: begin
                            cnt_next   = q_cmd.count;
                            idx_next   = '0;
                            state_next = BK_ERASE;
                            q_pop      = 1'b1;
                        end
                        CMD_CONVERT: begin
                            if (out_free) begin
                                emit        = 1'b1;
                                emit_action = ACTION_CONVERT;
                                emit_code   = '0;
                                emit_mode   = q_cmd.mode;
                                emit_last   = 1'b1;
                                q_pop       = 1'b1;
                            end
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_ERASE: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (idx_last) begin
                        idx_next   = '0;
                        state_next = BK_TOGGLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            BK_TOGGLE: begin
                idx_next = '0;
                if (out_free) begin
                    emit       = 1'b1;
                    emit_code  = toggle_reg;
                    state_next = BK_REPLAY;
                end
            end
            BK_REPLAY: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_code  = rd_data_reg[7:0];
                    emit_shift = rd_data_reg[8];
                    emit_last  = idx_last;
                    if (idx_last) begin
                        idx_next   = '0;
                        state_next = BK_IDLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    // layout toggle key register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            toggle_reg <= TOGGLE_RESET;
        end else if (cfg_we) begin
            toggle_reg <= cfg_wdata;
        end
    end

    // typed key buffer, read data follows the replay index
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[q_cmd.addr] <= q_cmd.entry;
        end
        rd_data_reg <= mem[idx_next];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_action_reg <= emit_action;
            out_code_reg   <= emit_code;
            out_shift_reg  <= emit_shift;
            out_mode_reg   <= emit_mode;
            out_last_reg   <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_action_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W-10){1'b0}}, out_mode_reg, out_shift_reg, out_code_reg};

endmodule

@@ rtl/keystroke_retype_layout_switcher.sv @@
// a conversion request passes from its input transfer via the command queue and output
// register, a first retype tap also via the erase state, once the queue ahead has drained
// throughput: one input transfer per cycle while the four-entry command queue has room;
// a retype of n buffered keys sends 2n+1 results, one per cycle while m_tready is high
// reset: synchronous active-low aresetn clears modifiers, count, flags and queue;
// toggle key returns to 58, buffer contents stay undefined until written
module keystroke_retype_layout_switcher
    import krls_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration: toggle key code
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    // key events
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // event code[7:0], event value[9:8], zero pad
    input  logic                s_tuser,   // is_key_event
    // results
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // tap_code[7:0], tap_shifted[8],
                                           // convert_mode[9], zero pad
    output logic                m_tuser,   // action
    output logic                m_tlast    // last
);

    q_status_t q_stat;
    logic      q_push;
    logic      q_pop;
    cmd_t      push_cmd;
    cmd_t      pop_cmd;

    // event classification and tracking state
    krls_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // command queue
    krls_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    // buffer and result sequencer
    krls_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ rtl/krls_checker.sv @@
module krls_checker
    import krls_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser,
    input logic                m_tlast
);

    // no result and an open input right after reset
    assert property (@(posedge aclk) !aresetn |=> (!m_tvalid && s_tready))
        else $error("result valid or input blocked after reset");

    // a conversion request is always the only result of its event
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ACTION_CONVERT) |-> m_tlast)
        else $error("conversion request not marked last");

    // a conversion request carries no tap code or shift flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ACTION_CONVERT) |-> (m_tdata[8:0] == 9'd0))
        else $error("conversion request with tap fields set");

    // a tap never carries a conversion mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ACTION_TAP) |-> !m_tdata[9])
        else $error("tap with conversion mode set");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind keystroke_retype_layout_switcher krls_checker u_krls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ verif/tb_keystroke_retype_layout_switcher.sv @@
module tb_keystroke_retype_layout_switcher;
    import krls_pkg::*;

    // key codes of the modifiers, as the block numbers its mask bits
    localparam logic [7:0] KEY_LSHIFT = 8'd42;
    localparam logic [7:0] KEY_RSHIFT = 8'd54;
    localparam logic [7:0] KEY_LCTRL  = 8'd29;
    localparam logic [7:0] KEY_RCTRL  = 8'd97;
    localparam logic [7:0] KEY_LWIN   = 8'd125;
    localparam logic [7:0] KEY_RWIN   = 8'd126;
    localparam logic [7:0] KEY_LALT   = 8'd56;
    localparam logic [7:0] KEY_RALT   = 8'd100;
    localparam logic [7:0] KEY_MAX    = 8'd255;

    // key values beyond release and press
    localparam logic [1:0] KEY_VAL_REPEAT = 2'd2;
    localparam logic [1:0] KEY_VAL_SPARE  = 2'd3;

    localparam int RANDOM_KEYS  = 300;
    localparam int SETTLE_TICKS = 8;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic       action;
        logic [7:0] code;
        logic       shifted;
        logic       mode;
        logic       last;
    } tap_result_t;

    typedef enum {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_PERIODIC,
        RDY_SPARSE
    } ready_mode_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [7:0]          cfg_wdata = 8'd0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;   // event code[7:0], event value[9:8], zero pad
    logic                s_tuser   = 1'b0; // is_key_event
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;          // tap_code[7:0], tap_shifted[8],
                                           // convert_mode[9], zero pad
    logic                m_tuser;          // action
    logic                m_tlast;

    // predicted state of the block
    logic [7:0]         held_mods;
    logic [ENTRY_W-1:0] typed_buf [BUFFER_DEPTH];
    int                 typed_len;
    logic               word_done;
    pend_t              armed_convert;
    logic [7:0]         toggle_code;

    tap_result_t expected_taps [$];
    tap_result_t want_r;
    tap_result_t got_r;

    int fault_count     = 0;
    int keys_sent       = 0;
    int burst_left      = 0;
    int hold_off_cycles = 0;
    int end_guard;

    keystroke_retype_layout_switcher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // modifier key to its mask bit
    function automatic logic [7:0] mod_bit_of(input logic [7:0] code);
        case (code)
            KEY_LSHIFT: return 8'h01;
            KEY_RSHIFT: return 8'h02;
            KEY_LCTRL:  return 8'h04;
            KEY_RCTRL:  return 8'h08;
            KEY_LWIN:   return 8'h10;
            KEY_RWIN:   return 8'h20;
            KEY_LALT:   return 8'h40;
            KEY_RALT:   return 8'h80;
            default:    return 8'h00;
        endcase
    endfunction

    // mask bit number to its modifier key
    function automatic logic [7:0] mod_code_of(input int idx);
        case (idx)
            0:       return KEY_LSHIFT;
            1:       return KEY_RSHIFT;
            2:       return KEY_LCTRL;
            3:       return KEY_RCTRL;
            4:       return KEY_LWIN;
            5:       return KEY_RWIN;
            6:       return KEY_LALT;
            default: return KEY_RALT;
        endcase
    endfunction

    // keys that land in the retype buffer
    function automatic logic is_typed_key(input logic [7:0] c);
        if (c >= 8'd2 && c <= 8'd12) return 1'b1;
        if (c >= 8'd16 && c <= 8'd27) return 1'b1;
        if (c >= 8'd30 && c <= 8'd41) return 1'b1;
        if (c >= 8'd44 && c <= 8'd52) return 1'b1;
        if (c >= 8'd71 && c <= 8'd73) return 1'b1;
        if (c >= 8'd75 && c <= 8'd77) return 1'b1;
        return c >= 8'd79 && c <= 8'd82;
    endfunction

    function automatic logic [7:0] pick_printable();
        logic [7:0] c;
        do c = 8'($urandom_range(2, 82)); while (!is_typed_key(c));
        return c;
    endfunction

    task automatic push_tap(input logic action, input logic [7:0] code,
                            input logic shifted, input logic mode);
        tap_result_t r;
        r.action  = action;
        r.code    = code;
        r.shifted = shifted;
        r.mode    = mode;
        r.last    = 1'b0;
        expected_taps.push_back(r);
    endtask

    // append to the buffer, a full buffer starts over
    task automatic store_typed(input logic [ENTRY_W-1:0] entry);
        if (typed_len >= BUFFER_DEPTH)
            typed_len = 0;
        typed_buf[typed_len] = entry;
        typed_len++;
    endtask

    task automatic clear_prediction();
        held_mods     = 8'd0;
        typed_len     = 0;
        word_done     = 1'b0;
        armed_convert = PEND_NONE;
        toggle_code   = TOGGLE_RESET;
    endtask

    // next state and results for one accepted key event
    task automatic predict_key_event(input logic is_key, input logic [7:0] code,
                                     input logic [1:0] val);
        logic [7:0]  mbit;
        logic [7:0]  mask;
        int          first;
        int          i;
        tap_result_t tail;
        if (!is_key)
            return;
        first = expected_taps.size();
        mbit  = mod_bit_of(code);
        mask  = held_mods;
        if (mbit != 8'd0) begin
            // any nonzero value holds the modifier
            if (val != KEY_VAL_RELEASE)
                mask = mask | mbit;
            else
                mask = mask & ~mbit;
            held_mods = mask;
            if (mask == 8'd0 && armed_convert != PEND_NONE) begin
                push_tap(ACTION_CONVERT, 8'd0, 1'b0, armed_convert == PEND_CASE);
                armed_convert = PEND_NONE;
            end
        end else if (is_typed_key(code)) begin
            if (val == KEY_VAL_PRESS) begin
                if ((mask & ~MASK_SHIFT) != 8'd0) begin
                    // chord clears the word, the save chord keeps it
                    if (code != KEY_S)
                        typed_len = 0;
                end else begin
                    if (word_done) begin
                        typed_len = 0;
                        word_done = 1'b0;
                    end
                    store_typed({(mask & MASK_SHIFT) != 8'd0, code});
                end
            end
        end else if (code == SPACE_CODE && mask == 8'd0) begin
            if (val == KEY_VAL_PRESS) begin
                word_done = 1'b1;
                store_typed({1'b0, code});
            end
        end else if (code == BKSP_CODE && mask == 8'd0) begin
            if (val == KEY_VAL_PRESS && typed_len > 0)
                typed_len--;
        end else if (code == PAUSE_CODE && mask == 8'd0) begin
            // retype: erase, switch layout, replay
            if (val == KEY_VAL_PRESS && typed_len > 0) begin
                for (i = 0; i < typed_len; i++)
                    push_tap(ACTION_TAP, BKSP_CODE, 1'b0, 1'b0);
                push_tap(ACTION_TAP, toggle_code, 1'b0, 1'b0);
                for (i = 0; i < typed_len; i++)
                    push_tap(ACTION_TAP, typed_buf[i][7:0], typed_buf[i][8], 1'b0);
            end
        end else if (code == PAUSE_CODE && (mask & MASK_ALT) != 8'd0) begin
            if (val == KEY_VAL_PRESS) begin
                typed_len     = 0;
                word_done     = 1'b0;
                armed_convert = PEND_LAYOUT;
            end
        end else if (code == PAUSE_CODE && (mask & MASK_SHIFT) != 8'd0) begin
            if (val == KEY_VAL_PRESS) begin
                typed_len     = 0;
                word_done     = 1'b0;
                armed_convert = PEND_CASE;
            end
        end else begin
            typed_len = 0;
            word_done = 1'b0;
        end
        // mark the final result of this event
        if (expected_taps.size() > first) begin
            tail = expected_taps.pop_back();
            tail.last = 1'b1;
            expected_taps.push_back(tail);
        end
    endtask

    // one input transfer, in bursts with random gaps between them
    task automatic put_event(input logic is_key, input logic [7:0] code,
                             input logic [1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, val, code};
        s_tuser  <= is_key;
        do @(posedge aclk); while (!s_tready);
        predict_key_event(is_key, code, val);
        if (is_key)
            keys_sent++;
    endtask

    // stop sending until every result is in, then let the block settle
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_taps.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_toggle(input logic [7:0] value);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        toggle_code = value;
    endtask

    // release held modifiers, starting from a given mask bit
    task automatic release_modifiers(input int start);
        logic [7:0] snap;
        int         j;
        int         idx;
        snap = held_mods;
        for (j = 0; j < 8; j++) begin
            idx = (start + j) % 8;
            if (snap[idx])
                put_event(1'b1, mod_code_of(idx), KEY_VAL_RELEASE);
        end
    endtask

    task automatic report_fault(input string what, input tap_result_t want,
                                input tap_result_t got);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display({"%0s: want act=%0d code=%0d sh=%0d mode=%0d last=%0d,",
                      " got act=%0d code=%0d sh=%0d mode=%0d last=%0d"},
                     what, want.action, want.code, want.shifted, want.mode, want.last,
                     got.action, got.code, got.shifted, got.mode, got.last);
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_r = {m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[9], m_tlast};
            if (expected_taps.size() == 0) begin
                report_fault("unexpected result", '0, got_r);
            end else begin
                want_r = expected_taps.pop_front();
                if (got_r.action !== want_r.action || got_r.code !== want_r.code ||
                    got_r.shifted !== want_r.shifted || got_r.mode !== want_r.mode ||
                    got_r.last !== want_r.last)
                    report_fault("result mismatch", want_r, got_r);
            end
        end
    end

    // receiver ready pattern, with an occasional long hold-off
    initial begin : sink_ready
        ready_mode_t mode;
        int          mode_left;
        int          phase_cnt;
        mode      = RDY_ALWAYS;
        mode_left = 0;
        phase_cnt = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end
            if (mode_left == 0) begin
                mode      = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase_cnt++;
            case (mode)
                RDY_ALWAYS:   m_tready <= 1'b1;
                RDY_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
                RDY_PERIODIC: m_tready <= ((phase_cnt % 5) < 3);
                default:      m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // field extremes, every key class and the corner cases
    task automatic test_directed_keys();
        put_event(1'b0, KEY_MAX, KEY_VAL_SPARE);
        put_event(1'b1, 8'd0, KEY_VAL_PRESS);
        put_event(1'b1, 8'd2, KEY_VAL_PRESS);
        put_event(1'b1, 8'd82, KEY_VAL_PRESS);
        put_event(1'b1, KEY_LSHIFT, KEY_VAL_PRESS);
        put_event(1'b1, 8'd16, KEY_VAL_PRESS);
        put_event(1'b1, 8'd16, KEY_VAL_RELEASE);
        put_event(1'b1, KEY_LSHIFT, KEY_VAL_RELEASE);
        put_event(1'b1, 8'd30, KEY_VAL_REPEAT);
        put_event(1'b1, BKSP_CODE, KEY_VAL_PRESS);
        put_event(1'b1, PAUSE_CODE, KEY_VAL_PRESS);
        put_event(1'b1, PAUSE_CODE, KEY_VAL_RELEASE);
        // space ends the word, the next letter starts a new one
        put_event(1'b1, SPACE_CODE, KEY_VAL_PRESS);
        put_event(1'b1, 8'd17, KEY_VAL_PRESS);
        // ctrl chords
        put_event(1'b1, KEY_LCTRL, KEY_VAL_PRESS);
        put_event(1'b1, KEY_S, KEY_VAL_PRESS);
        put_event(1'b1, PAUSE_CODE, KEY_VAL_PRESS);
        put_event(1'b1, 8'd30, KEY_VAL_PRESS);
        put_event(1'b1, KEY_LCTRL, KEY_VAL_RELEASE);
        // alt pause arms a layout swap, shift pause a case swap
        put_event(1'b1, KEY_RALT, KEY_VAL_SPARE);
        put_event(1'b1, PAUSE_CODE, KEY_VAL_PRESS);
        put_event(1'b1, KEY_RALT, KEY_VAL_RELEASE);
        put_event(1'b1, KEY_RSHIFT, KEY_VAL_PRESS);
        put_event(1'b1, PAUSE_CODE, KEY_VAL_PRESS);
        put_event(1'b1, KEY_RSHIFT, KEY_VAL_RELEASE);
        // other keys clear, empty buffer makes backspace and pause idle
        put_event(1'b1, KEY_MAX, KEY_VAL_RELEASE);
        put_event(1'b1, BKSP_CODE, KEY_VAL_PRESS);
        put_event(1'b1, PAUSE_CODE, KEY_VAL_PRESS);
        wait_results_drained();
    endtask

    // retype under several toggle key settings
    task automatic test_toggle_register();
        write_toggle(8'd0);
        put_event(1'b1, pick_printable(), KEY_VAL_PRESS);
        put_event(1'b1, pick_printable(), KEY_VAL_PRESS);
        put_event(1'b1, PAUSE_CODE, KEY_VAL_PRESS);
        write_toggle(8'd255);
        put_event(1'b1, PAUSE_CODE, KEY_VAL_PRESS);
        write_toggle(8'($urandom_range(0, 255)));
        put_event(1'b1, PAUSE_CODE, KEY_VAL_PRESS);
        write_toggle(TOGGLE_RESET);
    endtask

    // full buffer retypes while the receiver holds off
    task automatic test_receiver_holdoff();
        int k;
        wait_results_drained();
        release_modifiers(0);
        hold_off_cycles = 500;
        // seventeen keys wrap the buffer, then refill it completely
        for (k = 0; k < BUFFER_DEPTH + 1; k++)
            put_event(1'b1, pick_printable(), KEY_VAL_PRESS);
        put_event(1'b1, BKSP_CODE, KEY_VAL_PRESS);
        for (k = 0; k < BUFFER_DEPTH; k++)
            put_event(1'b1, pick_printable(), KEY_VAL_PRESS);
        for (k = 0; k < 5; k++) begin
            put_event(1'b1, PAUSE_CODE, KEY_VAL_PRESS);
            put_event(1'b1, PAUSE_CODE, KEY_VAL_RELEASE);
        end
        wait_results_drained();
    endtask

    // typing sequences with random content, chords and noise
    task automatic test_random_traffic();
        int         target;
        int         sel;
        int         len;
        int         k;
        int         pick;
        logic [7:0] c;
        target = keys_sent + RANDOM_KEYS;
        while (keys_sent < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
                // a word, then retype it
                release_modifiers(0);
                len = $urandom_range(1, 20);
                for (k = 0; k < len; k++) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 12) begin
                        c = pick_printable();
                        put_event(1'b1, c, KEY_VAL_PRESS);
                        if ($urandom_range(0, 1) == 1)
                            put_event(1'b1, c, KEY_VAL_RELEASE);
                    end else if (pick < 14) begin
                        if (held_mods[0])
                            put_event(1'b1, KEY_LSHIFT, KEY_VAL_RELEASE);
                        else if (held_mods[1])
                            put_event(1'b1, KEY_RSHIFT, KEY_VAL_RELEASE);
                        else
                            put_event(1'b1, ($urandom_range(0, 1) == 1) ? KEY_LSHIFT
                                                                         : KEY_RSHIFT,
                                      KEY_VAL_PRESS);
                    end else if (pick == 14) begin
                        put_event(1'b1, SPACE_CODE, KEY_VAL_PRESS);
                        put_event(1'b1, SPACE_CODE, KEY_VAL_RELEASE);
                    end else if (pick == 15) begin
                        put_event(1'b1, BKSP_CODE, KEY_VAL_PRESS);
                    end else if (pick == 16) begin
                        put_event(1'b1, KEY_S, KEY_VAL_PRESS);
                    end else if (pick == 17) begin
                        put_event(1'b1, pick_printable(), KEY_VAL_REPEAT);
                    end else begin
                        put_event(1'b1, 8'($urandom_range(0, 255)),
                                  2'($urandom_range(0, 3)));
                    end
                end
                release_modifiers(0);
                put_event(1'b1, PAUSE_CODE, KEY_VAL_PRESS);
                put_event(1'b1, PAUSE_CODE, KEY_VAL_RELEASE);
            end else if (sel < 65) begin
                // conversion request, fired when the last modifier goes up
                release_modifiers(0);
                if ($urandom_range(0, 1) == 1)
                    c = ($urandom_range(0, 1) == 1) ? KEY_LALT : KEY_RALT;
                else
                    c = ($urandom_range(0, 1) == 1) ? KEY_LSHIFT : KEY_RSHIFT;
                put_event(1'b1, c, 2'($urandom_range(1, 3)));
                if ($urandom_range(0, 2) == 0)
                    put_event(1'b1, mod_code_of($urandom_range(0, 7)), KEY_VAL_PRESS);
                if ($urandom_range(0, 3) == 0)
                    put_event(1'b1, pick_printable(), KEY_VAL_PRESS);
                put_event(1'b1, PAUSE_CODE, KEY_VAL_PRESS);
                if ($urandom_range(0, 1) == 1)
                    put_event(1'b1, PAUSE_CODE, KEY_VAL_RELEASE);
                release_modifiers($urandom_range(0, 7));
            end else if (sel < 75) begin
                // ctrl or win chords
                release_modifiers(0);
                put_event(1'b1, mod_code_of($urandom_range(2, 5)), KEY_VAL_PRESS);
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++) begin
                    pick = $urandom_range(0, 5);
                    if (pick == 0)
                        c = SPACE_CODE;
                    else if (pick == 1)
                        c = BKSP_CODE;
                    else if (pick == 2)
                        c = KEY_S;
                    else
                        c = pick_printable();
                    put_event(1'b1, c, KEY_VAL_PRESS);
                end
                release_modifiers(0);
            end else begin
                // noise
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    put_event($urandom_range(0, 7) != 0, 8'($urandom_range(0, 255)),
                              2'($urandom_range(0, 3)));
            end
            // phase boundaries: sometimes drain, sometimes drain and retune the toggle key
            pick = $urandom_range(0, 99);
            if (pick < 3)
                write_toggle(8'd0);
            else if (pick < 6)
                write_toggle(8'd255);
            else if (pick < 9)
                write_toggle(8'($urandom_range(0, 255)));
            else if (pick < 14)
                wait_results_drained();
        end
    endtask

    // main sequence
    initial begin
        clear_prediction();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_keys();
        test_toggle_register();
        test_receiver_holdoff();
        test_random_traffic();
        // drain with a bound, then settle
        s_tvalid  <= 1'b0;
        end_guard = 0;
        while (expected_taps.size() != 0 && end_guard < 20000) begin
            @(posedge aclk);
            end_guard++;
        end
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (expected_taps.size() != 0) begin
            $display("%0d expected results never arrived", expected_taps.size());
            fault_count = fault_count + expected_taps.size();
        end
        if (fault_count == 0)
            $display("tb_keystroke_retype_layout_switcher: clean");
        else
            $display("tb_keystroke_retype_layout_switcher: errors");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("tb_keystroke_retype_layout_switcher: errors");
        $finish;
    end

endmodule
